@@ design/tile_dominant_color_normalizer_top_assert.svh @@
// Assertion macros shared by the tile dominant color normalizer modules.
`ifndef TILE_DOMINANT_COLOR_NORMALIZER_TOP_ASSERT_SVH
`define TILE_DOMINANT_COLOR_NORMALIZER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TDCN_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tdcn assertion failed");
`define TDCN_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("tdcn forbidden condition seen");
`else
`define TDCN_ASSERT(lbl, prop)
`define TDCN_NEVER(lbl, expr)
`endif
`endif

@@ design/tdcn_pkg.sv @@
// Types, constants and helpers of the tile dominant color normalizer.
package tdcn_pkg;

    localparam int PAT_W   = 8;
    localparam int COLOR_W = 4;
    localparam int COUNT_W = 7;
    localparam int ONES_W  = 4;

    localparam logic [ONES_W-1:0] PIX_PER_ROW = 4'd8;

    typedef struct packed {
        logic [PAT_W-1:0]   row_pattern;
        logic [COLOR_W-1:0] fore_color;
        logic [COLOR_W-1:0] back_color;
    } row_item_t;

    typedef struct packed {
        logic [PAT_W-1:0]   out_pattern;
        logic [COLOR_W-1:0] out_fore;
        logic [COLOR_W-1:0] out_back;
        logic [COLOR_W-1:0] dominant_color;
        logic               last_row;
    } result_item_t;

    typedef struct packed {
        logic               row_go;
        logic               scan_go;
        logic [COLOR_W-1:0] fore;
        logic [COLOR_W-1:0] back;
        logic [ONES_W-1:0]  ones;
    } hist_cmd_t;

    typedef struct packed {
        logic               busy;
        logic [COLOR_W-1:0] dominant;
    } hist_stat_t;

    function automatic logic [ONES_W-1:0] count_ones(input logic [PAT_W-1:0] v);
        logic [ONES_W-1:0] n;
        n = '0;
        for (int i = 0; i < PAT_W; i++)
        begin
            n = n + ONES_W'(v[i]);
        end
        return n;
    endfunction

endpackage

@@ design/tdcn_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tdcn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/tdcn_hist.sv @@
// Color histogram: per-row count update and dominant color scan.
`include "tile_dominant_color_normalizer_top_assert.svh"

module tdcn_hist #(
    parameter int NUM_COLORS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tdcn_pkg::hist_cmd_t   cmd,
    output tdcn_pkg::hist_stat_t  stat
);

    import tdcn_pkg::*;

    localparam int CA = (NUM_COLORS > 1) ? $clog2(NUM_COLORS) : 1;
    localparam int VD = 1 << CA;
    localparam logic [COLOR_W:0] NC_LIM   = NUM_COLORS[COLOR_W:0];
    localparam logic [CA-1:0]    LAST_IDX = CA'(NUM_COLORS - 1);

    localparam logic [1:0] H_IDLE = 2'd0;
    localparam logic [1:0] H_FG   = 2'd1;
    localparam logic [1:0] H_BG   = 2'd2;
    localparam logic [1:0] H_SCAN = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [VD-1:0]      valid_reg, valid_next;
    logic [COLOR_W-1:0] fore_reg, fore_next;
    logic [COLOR_W-1:0] back_reg, back_next;
    logic [ONES_W-1:0]  ones_reg, ones_next;
    logic [COUNT_W-1:0] fg_sum_reg, fg_sum_next;
    logic [CA-1:0]      idx_reg, idx_next;
    logic [COLOR_W-1:0] best_reg, best_next;
    logic [COUNT_W-1:0] best_cnt_reg, best_cnt_next;

    logic               wr_en;
    logic [CA-1:0]      wr_addr;
    logic [COUNT_W-1:0] wr_data;
    logic               rd_en;
    logic [CA-1:0]      rd_addr;
    logic [COUNT_W-1:0] rd_data;

    logic [CA-1:0]      fore_idx, back_idx;
    logic               fore_ok, back_ok;
    logic [COUNT_W-1:0] fg_cnt, fg_sum, bg_cnt, bg_sum, scan_cnt;

    tdcn_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (NUM_COLORS)
    ) u_count_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign fore_idx = fore_reg[CA-1:0];
    assign back_idx = back_reg[CA-1:0];
    assign fore_ok  = {1'b0, fore_reg} < NC_LIM;
    assign back_ok  = {1'b0, back_reg} < NC_LIM;

    // Same color on both sides: take the count just written for the foreground.
    assign fg_cnt   = valid_reg[fore_idx] ? rd_data : '0;
    assign fg_sum   = fg_cnt + COUNT_W'(ones_reg);
    assign bg_cnt   = (back_reg == fore_reg) ? fg_sum_reg
                    : (valid_reg[back_idx] ? rd_data : '0);
    assign bg_sum   = bg_cnt + COUNT_W'(PIX_PER_ROW - ones_reg);
    assign scan_cnt = valid_reg[idx_reg] ? rd_data : '0;

    always_comb
    begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        fore_next     = fore_reg;
        back_next     = back_reg;
        ones_next     = ones_reg;
        fg_sum_next   = fg_sum_reg;
        idx_next      = idx_reg;
        best_next     = best_reg;
        best_cnt_next = best_cnt_reg;
        wr_en         = 1'b0;
        wr_addr       = fore_idx;
        wr_data       = fg_sum;
        rd_en         = 1'b0;
        rd_addr       = cmd.fore[CA-1:0];

        unique case (state_reg)
            H_IDLE:
            begin
                if (cmd.row_go)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = cmd.fore[CA-1:0];
                    fore_next  = cmd.fore;
                    back_next  = cmd.back;
                    ones_next  = cmd.ones;
                    state_next = H_FG;
                end
                else if (cmd.scan_go)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = '0;
                    idx_next      = '0;
                    best_next     = '0;
                    best_cnt_next = '0;
                    state_next    = H_SCAN;
                end
            end
            H_FG:
            begin
                fg_sum_next = fg_sum;
                if (fore_ok)
                begin
                    wr_en                = 1'b1;
                    wr_addr              = fore_idx;
                    wr_data              = fg_sum;
                    valid_next[fore_idx] = 1'b1;
                end
                rd_en      = 1'b1;
                rd_addr    = back_idx;
                state_next = H_BG;
            end
            H_BG:
            begin
                if (back_ok)
                begin
                    wr_en                = 1'b1;
                    wr_addr              = back_idx;
                    wr_data              = bg_sum;
                    valid_next[back_idx] = 1'b1;
                end
                state_next = H_IDLE;
            end
            H_SCAN:
            begin
                if (scan_cnt > best_cnt_reg)
                begin
                    best_cnt_next = scan_cnt;
                    best_next     = COLOR_W'(idx_reg);
                end
                if (idx_reg == LAST_IDX)
                begin
                    valid_next = '0;
                    state_next = H_IDLE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fore_reg     <= fore_next;
        back_reg     <= back_next;
        ones_reg     <= ones_next;
        fg_sum_reg   <= fg_sum_next;
        idx_reg      <= idx_next;
        best_reg     <= best_next;
        best_cnt_reg <= best_cnt_next;
    end

    assign stat.busy     = state_reg != H_IDLE;
    assign stat.dominant = best_reg;

    `TDCN_ASSERT(a_cmd_when_idle, (cmd.row_go || cmd.scan_go) |-> (state_reg == H_IDLE))
    `TDCN_NEVER(a_cmd_exclusive, cmd.row_go && cmd.scan_go)
    `TDCN_ASSERT(a_bg_after_fg, (state_reg == H_BG) |-> ($past(state_reg) == H_FG))
    `TDCN_ASSERT(a_clear_after_scan, (state_reg == H_SCAN && idx_reg == LAST_IDX) |=> (valid_reg == '0))

endmodule

@@ design/tile_dominant_color_normalizer_top.sv @@
// Top level of the tile dominant color normalizer.
// Rows of a tile enter one item at a time; row_stall holds off the next row
// during the read-modify-write of its foreground and background counts in the
// histogram RAM (one read port, registered read). The item that completes a
// tile starts a scan of the histogram, one histogram entry per cycle, and then
// the rows leave as result items, each a row store read followed by the output
// register load, which waits while the output side stalls. The histogram is
// cleared by per-color valid bits at the end of each scan, so no clearing pass
// is needed.
`include "tile_dominant_color_normalizer_top_assert.svh"

module tile_dominant_color_normalizer_top #(
    parameter int TILE_ROWS  = 8,
    parameter int NUM_COLORS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   row_valid,
    output logic                   row_stall,
    input  tdcn_pkg::row_item_t    row,
    output logic                   result_valid,
    input  logic                   result_stall,
    output tdcn_pkg::result_item_t result
);

    import tdcn_pkg::*;

    localparam int RA = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
    localparam logic [RA-1:0] LAST_ROW = RA'(TILE_ROWS - 1);

    localparam logic [2:0] S_LOAD      = 3'd0;
    localparam logic [2:0] S_SCAN_GO   = 3'd1;
    localparam logic [2:0] S_SCAN_WAIT = 3'd2;
    localparam logic [2:0] S_EMIT_RD   = 3'd3;
    localparam logic [2:0] S_EMIT_WR   = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [RA-1:0] rows_loaded_reg, rows_loaded_next;
    logic [RA-1:0] emit_idx_reg, emit_idx_next;
    logic          result_valid_reg, result_valid_next;
    result_item_t  result_reg, result_next;

    hist_cmd_t     hist_cmd;
    hist_stat_t    hist_stat;

    logic          row_accept;
    logic          result_take;
    logic          out_free;
    logic          load_result;
    logic          row_rd_en;
    row_item_t     row_rdata;
    logic          swap;

    tdcn_hist #(
        .NUM_COLORS (NUM_COLORS)
    ) u_hist (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (hist_cmd),
        .stat  (hist_stat)
    );

    tdcn_ram #(
        .WIDTH ($bits(row_item_t)),
        .DEPTH (TILE_ROWS)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (row_accept),
        .wr_addr (rows_loaded_reg),
        .wr_data (row),
        .rd_en   (row_rd_en),
        .rd_addr (emit_idx_reg),
        .rd_data (row_rdata)
    );

    assign row_stall   = (state_reg != S_LOAD) || hist_stat.busy;
    assign row_accept  = row_valid && !row_stall;
    assign result_take = result_valid_reg && !result_stall;
    assign out_free    = !result_valid_reg || !result_stall;
    assign swap        = row_rdata.fore_color == hist_stat.dominant;

    always_comb
    begin
        state_next       = state_reg;
        rows_loaded_next = rows_loaded_reg;
        emit_idx_next    = emit_idx_reg;
        load_result      = 1'b0;
        row_rd_en        = 1'b0;

        hist_cmd.row_go  = row_accept;
        hist_cmd.scan_go = 1'b0;
        hist_cmd.fore    = row.fore_color;
        hist_cmd.back    = row.back_color;
        hist_cmd.ones    = count_ones(row.row_pattern);

        unique case (state_reg)
            S_LOAD:
            begin
                if (row_accept)
                begin
                    if (rows_loaded_reg == LAST_ROW)
                    begin
                        rows_loaded_next = '0;
                        state_next       = S_SCAN_GO;
                    end
                    else
                    begin
                        rows_loaded_next = rows_loaded_reg + 1'b1;
                    end
                end
            end
            S_SCAN_GO:
            begin
                if (!hist_stat.busy)
                begin
                    hist_cmd.scan_go = 1'b1;
                    state_next       = S_SCAN_WAIT;
                end
            end
            S_SCAN_WAIT:
            begin
                if (!hist_stat.busy)
                begin
                    emit_idx_next = '0;
                    state_next    = S_EMIT_RD;
                end
            end
            S_EMIT_RD:
            begin
                row_rd_en  = 1'b1;
                state_next = S_EMIT_WR;
            end
            S_EMIT_WR:
            begin
                if (out_free)
                begin
                    load_result = 1'b1;
                    if (emit_idx_reg == LAST_ROW)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg + 1'b1;
                        state_next    = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_comb
    begin
        result_next = result_reg;
        if (load_result)
        begin
            result_next.out_pattern    = swap ? ~row_rdata.row_pattern : row_rdata.row_pattern;
            result_next.out_fore       = swap ? row_rdata.back_color : row_rdata.fore_color;
            result_next.out_back       = swap ? row_rdata.fore_color : row_rdata.back_color;
            result_next.dominant_color = hist_stat.dominant;
            result_next.last_row       = emit_idx_reg == LAST_ROW;
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (load_result)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_take)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_LOAD;
            rows_loaded_reg  <= '0;
            emit_idx_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            rows_loaded_reg  <= rows_loaded_next;
            emit_idx_reg     <= emit_idx_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `TDCN_ASSERT(a_count_zero_off_load, (state_reg != S_LOAD) |-> (rows_loaded_reg == '0))
    `TDCN_ASSERT(a_valid_rise_from_emit, $rose(result_valid_reg) |-> ($past(state_reg) == S_EMIT_WR))
    `TDCN_ASSERT(a_last_back_to_load, (load_result && result_next.last_row) |=> (state_reg == S_LOAD))
    `TDCN_ASSERT(a_dominant_held, (state_reg == S_EMIT_WR) |-> $stable(hist_stat.dominant))

endmodule
